// ===== design/rrap_pkg.sv =====
// Package for the ray ring picker: shared types, codes and reset values.
// Used by the interfaces, the root/divide unit and the top level.
package rrap_pkg;

	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_RING_RADIUS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RING_THICKNESS = 2'd1;

	localparam logic [30:0] RADIUS_RST = 31'd98304;
	localparam logic [30:0] THICK_RST  = 31'd13107;
	localparam logic [30:0] SAT_MAX    = 31'h7FFF_FFFF;

	localparam logic [1:0] AXIS_NONE = 2'd0;
	localparam logic [1:0] AXIS_BAD  = 2'd3;

	localparam logic [5:0] SQRT_STEPS  = 6'd32;
	localparam logic [5:0] DIV_T_STEPS = 6'd31;

	// request to the shared root/divide unit
	typedef struct packed {
		logic        start;
		logic        is_sqrt;
		logic [63:0] init;     // radicand, or upper part of the dividend
		logic [31:0] low;      // remaining dividend bits, left aligned
		logic [5:0]  steps;
		logic [63:0] divisor;
	} sqdiv_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} sqdiv_rsp_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] x);
		logic [31:0] r;
		r = x[31] ? 32'(-x) : 32'(x);
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] x);
		logic [63:0] r;
		r = x[63] ? 64'(-x) : 64'(x);
		return r;
	endfunction

endpackage

// ===== design/rrap_ifs.sv =====
// Channel interfaces of the ray ring picker: configuration, input and result.
// Depends on rrap_pkg for the index width.
interface rrap_cfg_if import rrap_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

interface rrap_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         axis_index;
	logic               local_space;
	logic signed [31:0] axis_col_x;
	logic signed [31:0] axis_col_y;
	logic signed [31:0] axis_col_z;
	logic signed [31:0] ray_dir_x;
	logic signed [31:0] ray_dir_y;
	logic signed [31:0] ray_dir_z;
	logic signed [31:0] center_offset_x;
	logic signed [31:0] center_offset_y;
	logic signed [31:0] center_offset_z;
	logic               last_axis;
	modport source(output valid, axis_index, local_space, axis_col_x, axis_col_y,
		axis_col_z, ray_dir_x, ray_dir_y, ray_dir_z, center_offset_x, center_offset_y,
		center_offset_z, last_axis, input ready);
	modport sink(input valid, axis_index, local_space, axis_col_x, axis_col_y,
		axis_col_z, ray_dir_x, ray_dir_y, ray_dir_z, center_offset_x, center_offset_y,
		center_offset_z, last_axis, output ready);
endinterface

interface rrap_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  picked_axis;
	logic [30:0] best_distance;
	modport source(output valid, picked_axis, best_distance, input ready);
	modport sink(input valid, picked_axis, best_distance, output ready);
endinterface

// ===== design/ray_ring_axis_picker.sv =====
// Ray ring picker top level: sequencer around one multiplier and one root/divide unit.
// Run time per axis word is set by the roots and divisions in rrap_sqdiv: one root
// in global space, two in local space. One axis word at a time; a pick result is
// registered in S_DONE after its last axis word, waiting while the previous is unread.
// Reset (arst_n low) clears the best ring, restores radius 1.5 and thickness 0.2.
// Depends on rrap_pkg, rrap_ifs, rrap_mul and rrap_sqdiv.
module ray_ring_axis_picker_core import rrap_pkg::*; #(
	parameter int unsigned FRAC_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	rrap_cfg_if.sink   cfg,
	rrap_in_if.sink    in_ch,
	rrap_out_if.source out_ch
);

	localparam int unsigned NW = FRAC_BITS + 2;
	localparam logic [63:0] TinyLen2 =
		((64'd1 << (2 * FRAC_BITS)) + 64'd9999999999) / 64'd10000000000;
	localparam logic [63:0] TinyDen =
		((64'd1 << (2 * FRAC_BITS)) + 64'd99999) / 64'd100000;
	localparam logic [5:0] NormSteps = 6'(FRAC_BITS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_COLSQ, S_COLCHK, S_LEN_WAIT, S_NDIV, S_NDIV_WAIT, S_DEN, S_NUM,
		S_CHK, S_TDIV_WAIT, S_HIT, S_MSQ, S_DIST, S_DIST_WAIT, S_CMP, S_DONE
	} state_t;

	state_t state_q;

	logic [1:0]               axis_q;
	logic                     last_q;
	logic signed [31:0]       col_q [3];
	logic signed [31:0]       dir_q [3];
	logic signed [31:0]       off_q [3];
	logic signed [NW-1:0]     n_q   [3];
	logic [63:0]              m_q   [3];
	logic [63:0]              acc_q, den_q, len_q, dlen_q;
	logic [30:0]              t_q;
	logic [1:0]               idx_q;
	logic [31:0]              best_score_q;
	logic [1:0]               best_ring_q;
	logic [30:0]              radius_q, thick_q;
	logic                     out_valid_q;
	logic [1:0]               out_axis_q;
	logic [30:0]              out_dist_q;

	logic [1:0]               ei, pj;
	logic signed [32:0]       mul_a, mul_b;
	logic signed [65:0]       p_s1;
	logic [63:0]              mac_nx;
	logic                     far;
	logic [63:0]              num_mag, den_mag, a_fr;
	logic signed [65:0]       v_w;
	logic [63:0]              d_w;
	sqdiv_req_t               req;
	sqdiv_rsp_t               rsp;

	rrap_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_s1(p_s1));
	rrap_sqdiv u_sqdiv (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	assign ei = (idx_q == 2'd3) ? 2'd0 : idx_q;
	assign pj = idx_q - 2'd1;
	assign far = (m_q[0][63:31] != '0) || (m_q[1][63:31] != '0) || (m_q[2][63:31] != '0);
	assign mac_nx = (idx_q == 2'd1) ? p_s1[63:0] : acc_q + p_s1[63:0];
	assign num_mag = mag64(acc_q);
	assign den_mag = mag64(den_q);
	assign a_fr = num_mag << FRAC_BITS;
	assign v_w = (p_s1 >>> FRAC_BITS) - 66'(off_q[pj]);
	assign d_w = (dlen_q >= 64'(radius_q)) ? dlen_q - 64'(radius_q) : 64'(radius_q) - dlen_q;

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_COLSQ: begin
				mul_a = 33'(mag32(col_q[ei]));
				mul_b = 33'(mag32(col_q[ei]));
			end
			S_DEN: begin
				mul_a = 33'(dir_q[ei]);
				mul_b = 33'(n_q[ei]);
			end
			S_NUM: begin
				mul_a = 33'(off_q[ei]);
				mul_b = 33'(n_q[ei]);
			end
			S_HIT: begin
				mul_a = 33'(dir_q[ei]);
				mul_b = {2'b00, t_q};
			end
			S_MSQ: begin
				mul_a = far ? {1'b0, 32'(m_q[ei] >> FRAC_BITS)} : {1'b0, m_q[ei][31:0]};
				mul_b = mul_a;
			end
			default: ;
		endcase
	end

	always_comb begin
		req = '0;
		case (state_q)
			S_COLCHK: begin
				req.start   = acc_q >= TinyLen2;
				req.is_sqrt = 1'b1;
				req.init    = acc_q;
				req.steps   = SQRT_STEPS;
			end
			S_NDIV: begin
				// the magnitude keeps the parity of the signed value
				req.start   = 1'b1;
				req.init    = 64'(mag32(col_q[ei]) >> 1);
				req.low     = {col_q[ei][0], 31'd0};
				req.steps   = NormSteps;
				req.divisor = len_q;
			end
			S_CHK: begin
				req.start   = (den_mag >= TinyDen)
					&& !(acc_q != '0 && (acc_q[63] != den_q[63]))
					&& ((num_mag >> (31 - FRAC_BITS)) < den_mag);
				req.init    = num_mag >> (31 - FRAC_BITS);
				req.low     = {a_fr[30:0], 1'b0};
				req.steps   = DIV_T_STEPS;
				req.divisor = den_mag;
			end
			S_DIST: begin
				req.start   = 1'b1;
				req.is_sqrt = 1'b1;
				req.init    = acc_q;
				req.steps   = SQRT_STEPS;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			idx_q        <= '0;
			best_score_q <= '1;
			best_ring_q  <= AXIS_NONE;
			radius_q     <= RADIUS_RST;
			thick_q      <= THICK_RST;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == CFG_RING_RADIUS) radius_q <= cfg.data[30:0];
				else if (cfg.index == CFG_RING_THICKNESS) thick_q <= cfg.data[30:0];
			end
			if (out_valid_q && out_ch.ready && !(state_q == S_DONE && last_q))
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						idx_q <= '0;
						if (in_ch.axis_index == AXIS_BAD) state_q <= S_DONE;
						else if (in_ch.local_space) state_q <= S_COLSQ;
						else state_q <= S_DEN;
					end
				end
				S_COLSQ, S_DEN, S_NUM, S_HIT, S_MSQ: begin
					// index wraps back to zero after the last pass
					idx_q <= idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						case (state_q)
							S_COLSQ: state_q <= S_COLCHK;
							S_DEN:   state_q <= S_NUM;
							S_NUM:   state_q <= S_CHK;
							S_HIT:   state_q <= S_MSQ;
							default: state_q <= S_DIST;
						endcase
					end
				end
				S_COLCHK: state_q <= req.start ? S_LEN_WAIT : S_DEN;
				S_LEN_WAIT: if (rsp.done) state_q <= S_NDIV;
				S_NDIV: state_q <= S_NDIV_WAIT;
				S_NDIV_WAIT: begin
					if (rsp.done) begin
						if (idx_q == 2'd2) begin
							idx_q   <= '0;
							state_q <= S_DEN;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_NDIV;
						end
					end
				end
				S_CHK: begin
					if (den_mag < TinyDen) state_q <= S_DONE;
					else if (acc_q != '0 && (acc_q[63] != den_q[63])) state_q <= S_DONE;
					else if (req.start) state_q <= S_TDIV_WAIT;
					else state_q <= S_HIT;
				end
				S_TDIV_WAIT: if (rsp.done) state_q <= S_HIT;
				S_DIST: state_q <= S_DIST_WAIT;
				S_DIST_WAIT: if (rsp.done) state_q <= S_CMP;
				S_CMP: begin
					if (d_w <= 64'(thick_q) && d_w < 64'(best_score_q)) begin
						best_score_q <= d_w[31:0];
						best_ring_q  <= axis_q + 2'd1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						best_score_q <= '1;
						best_ring_q  <= AXIS_NONE;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			axis_q  <= in_ch.axis_index;
			last_q  <= in_ch.last_axis;
			col_q   <= '{in_ch.axis_col_x, in_ch.axis_col_y, in_ch.axis_col_z};
			dir_q   <= '{in_ch.ray_dir_x, in_ch.ray_dir_y, in_ch.ray_dir_z};
			off_q   <= '{in_ch.center_offset_x, in_ch.center_offset_y, in_ch.center_offset_z};
			for (int k = 0; k < 3; k++) begin
				n_q[k] <= (in_ch.axis_index == 2'(k)) ? NW'(1) << FRAC_BITS : '0;
			end
		end
		if ((state_q == S_COLSQ || state_q == S_DEN || state_q == S_NUM
			|| state_q == S_MSQ) && idx_q != 2'd0) begin
			acc_q <= mac_nx;
		end
		if (state_q == S_DEN && idx_q == 2'd3) den_q <= mac_nx;
		if (state_q == S_HIT && idx_q != 2'd0) m_q[pj] <= mag64(v_w[63:0]);
		if (state_q == S_LEN_WAIT && rsp.done) len_q <= rsp.result;
		if (state_q == S_NDIV_WAIT && rsp.done) begin
			n_q[ei] <= col_q[ei][31] ? NW'(-rsp.result) : NW'(rsp.result);
		end
		if (state_q == S_CHK) t_q <= SAT_MAX;
		if (state_q == S_TDIV_WAIT && rsp.done) t_q <= rsp.result[30:0];
		if (state_q == S_DIST_WAIT && rsp.done) begin
			dlen_q <= far ? rsp.result << FRAC_BITS : rsp.result;
		end
		if (state_q == S_DONE && last_q && (!out_valid_q || out_ch.ready)) begin
			out_axis_q <= best_ring_q;
			out_dist_q <= (best_ring_q != AXIS_NONE) ? best_score_q[30:0] : SAT_MAX;
		end
	end

	assign cfg.ready            = 1'b1;
	assign in_ch.ready          = (state_q == S_IDLE);
	assign out_ch.valid         = out_valid_q;
	assign out_ch.picked_axis   = out_axis_q;
	assign out_ch.best_distance = out_dist_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !rsp.busy) else $error("root/divide unit restarted while busy");

	a_done_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> (state_q == S_LEN_WAIT || state_q == S_NDIV_WAIT
			|| state_q == S_TDIV_WAIT || state_q == S_DIST_WAIT))
		else $error("unit result with no sequencer waiting");

	a_none_max: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_axis_q == AXIS_NONE |-> out_dist_q == SAT_MAX)
		else $error("empty pick without maximum distance");

endmodule

// ===== design/rrap_mul.sv =====
// Registered signed 33 x 33 multiplier shared by all products of the picker.
// Self-contained.
module rrap_mul (
	input  logic               clk,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_s1
);

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

// ===== design/rrap_sqdiv.sv =====
// Shared bit-serial unit: integer square root (two bits a step) and
// restoring division (one quotient bit a step). Depends on rrap_pkg.
module rrap_sqdiv import rrap_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  sqdiv_req_t req,
	output sqdiv_rsp_t rsp
);

	logic        busy_q, done_q, is_sqrt_q;
	logic [5:0]  cnt_q;
	logic [63:0] v_q, res_q, bit_q, div_q;
	logic [31:0] low_q;
	logic [63:0] acc_w, sub_w;
	logic        ge;

	always_comb begin
		acc_w = is_sqrt_q ? v_q : {v_q[62:0], low_q[31]};
		sub_w = is_sqrt_q ? res_q + bit_q : div_q;
		ge    = acc_w >= sub_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			is_sqrt_q <= req.is_sqrt;
			v_q       <= req.init;
			low_q     <= req.low;
			res_q     <= '0;
			bit_q     <= 64'h4000_0000_0000_0000;
			div_q     <= req.divisor;
		end else if (busy_q) begin
			if (is_sqrt_q) begin
				if (ge) begin
					v_q   <= acc_w - sub_w;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end else begin
				v_q   <= ge ? acc_w - sub_w : acc_w;
				res_q <= {res_q[62:0], ge};
				low_q <= low_q << 1;
			end
		end
	end

	assign rsp.busy   = busy_q;
	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule
